// ===== rtl/pfba_pkg.sv =====
// Shared constants, types and helper functions of the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

  // Bitmap geometry.
  localparam int BITMAP_WORDS = 1024;
  localparam int WORD_BITS    = 32;
  localparam int PAGE_BYTES   = 4096;

  localparam int ADDR_W      = 32;
  localparam int CFG_IDX_W   = 8;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int WORD_IDX_W  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int TOTAL_PAGES = BITMAP_WORDS * WORD_BITS;

  // Pages whose byte address fits in the address width.
  localparam int ADDR_PAGES_W = ADDR_W - PAGE_SHIFT;
  localparam int ADDR_PAGES   = 2 ** ADDR_PAGES_W;
  localparam int SCAN_PAGES   = (ADDR_PAGES < TOTAL_PAGES) ? ADDR_PAGES : TOTAL_PAGES;
  localparam int SCAN_LAST_WORD = (SCAN_PAGES - 1) / WORD_BITS;
  localparam int SCAN_LAST_BITS = SCAN_PAGES - SCAN_LAST_WORD * WORD_BITS;

  // Page numbers of the reserved range reach twice the addressable page count.
  localparam int RANGE_W = ((ADDR_PAGES_W + 2) > ($clog2(TOTAL_PAGES) + 1)) ?
                           (ADDR_PAGES_W + 2) : ($clog2(TOTAL_PAGES) + 1);

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;
  typedef logic [RANGE_W-1:0]    range_t;

  localparam word_t     WORD_ONES      = {WORD_BITS{1'b1}};
  localparam word_t     LAST_WORD_MASK = WORD_ONES >> (WORD_BITS - SCAN_LAST_BITS);
  localparam word_idx_t SCAN_LAST_IDX  = word_idx_t'(SCAN_LAST_WORD);
  localparam word_idx_t SWEEP_LAST_IDX = word_idx_t'(BITMAP_WORDS - 1);
  localparam range_t    TOTAL_PAGES_R  = range_t'(TOTAL_PAGES);
  localparam range_t    SCAN_PAGES_R   = range_t'(SCAN_PAGES);

  typedef enum logic [1:0] {
    OP_INIT      = 2'd0,
    OP_MARK_USED = 2'd1,
    OP_MARK_FREE = 2'd2,
    OP_ALLOC     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BEYOND = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESV_END  = CFG_IDX_W'(1);

  // Index of the lowest set bit; zero when none is set.
  function automatic bit_idx_t lowest_set(word_t v);
    bit_idx_t idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = bit_idx_t'(i);
    end
    return idx;
  endfunction

  // Bits of the word starting at page base that fall inside [first, last).
  function automatic word_t range_mask(range_t base, range_t first, range_t last);
    range_t   top;
    bit_idx_t lo;
    bit_idx_t hi;
    word_t    m;
    top = base + range_t'(WORD_BITS);
    lo  = '0;
    hi  = '0;
    m   = '0;
    if (first < last && first < top && last > base) begin
      if (first > base) lo = bit_idx_t'(first - base);
      m = WORD_ONES << lo;
      if (last < top) begin
        hi = bit_idx_t'(last - base);
        m  = m & ~(WORD_ONES << hi);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/page_frame_bitmap_allocator_core.sv =====
// Top level of the page frame bitmap allocator: sequencer, bitmap memory and search unit.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/in_tready | tdata: frame address; tuser: opcode
//  out_    | master    | out_tvalid/tready   | tdata: alloc_addr; tuser: status
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index (0 base address, 1 reserved end), data
//
// Init sweeps every bitmap word; mark reads and writes back one word (neither when the address is
// beyond the bitmap); allocate reads the bitmap words that the search needs, one word per
// cycle through the single read port (none when the base address lies beyond the bitmap).
// After reset a clearing pass writes zero to every bitmap word, one per cycle; in_tready
// stays low meanwhile, configuration writes are taken.
// A finished result waits in the output register while the next transaction is accepted;
// a result that finds that register still full holds the sequencer until it drains.
`default_nettype none

module page_frame_bitmap_allocator_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: frame address [31:0]
  input  wire logic [pfba_pkg::ADDR_W-1:0]    in_tdata,
  // in_tuser: opcode [1:0]
  input  wire logic [1:0]                     in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: alloc_addr [31:0]
  output logic [pfba_pkg::ADDR_W-1:0]         out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]                          out_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pfba_pkg::ADDR_W-1:0]    cfg_data
);

  import pfba_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC_CNT,
    ST_CALC_LAST,
    ST_SWEEP,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_ALLOC_RD,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   base_addr_r;
  logic [ADDR_W-1:0]   resv_end_r;
  word_idx_t           cur_r;
  bit_idx_t            bit_r;
  logic                first_word_r;
  logic                mark_set_r;
  range_t              first_r;
  range_t              last_r;
  logic [ADDR_W-1:0]   res_addr_r;
  status_t             res_status_r;
  logic [ADDR_W-1:0]   out_tdata_r;
  logic [1:0]          out_tuser_r;
  logic                out_tvalid_r;
  word_t               rdata_r;

  word_t               mem [BITMAP_WORDS];

  word_idx_t           rd_addr;
  logic                mem_we;
  word_t               mem_wd;
  logic                resp_load;

  // Decode of the incoming transaction.
  range_t              in_page;
  logic                in_beyond;
  range_t              start_page;

  // Search unit.
  word_t               avail;
  logic                found;
  bit_idx_t            found_bit;
  word_t               found_onehot;
  word_t               bit_onehot;

  // Reservation arithmetic.
  logic [ADDR_W-1:0]   span;
  range_t              span_pages;
  range_t              range_end;
  range_t              sweep_base;

  assign in_page    = range_t'(in_tdata[ADDR_W-1:PAGE_SHIFT]);
  assign in_beyond  = (in_page >= TOTAL_PAGES_R);
  assign start_page = range_t'(base_addr_r[ADDR_W-1:PAGE_SHIFT]);

  assign span       = resv_end_r - base_addr_r;
  assign span_pages = range_t'(span[ADDR_W-1:PAGE_SHIFT]) +
                      range_t'(|span[PAGE_SHIFT-1:0]);
  assign range_end  = first_r + last_r;
  assign sweep_base = range_t'(cur_r) << BIT_IDX_W;

  always_comb begin
    avail = ~rdata_r;
    if (first_word_r) avail = avail & (WORD_ONES << bit_r);
    if (cur_r == SCAN_LAST_IDX) avail = avail & LAST_WORD_MASK;
  end

  assign found        = (avail != '0);
  assign found_bit    = lowest_set(avail);
  assign found_onehot = word_t'(1) << found_bit;
  assign bit_onehot   = word_t'(1) << bit_r;

  // While searching, the next word is fetched while the current one is examined.
  assign rd_addr = (state_r == ST_SCAN) ? word_idx_t'(cur_r + 1'b1) : cur_r;

  assign resp_load = (state_r == ST_RESP) && (!out_tvalid_r || out_tready);

  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        mem_wd = range_mask(sweep_base, first_r, last_r);
      end
      ST_MARK_WR: begin
        mem_we = 1'b1;
        mem_wd = mark_set_r ? (rdata_r | bit_onehot) : (rdata_r & ~bit_onehot);
      end
      ST_SCAN: begin
        mem_we = found;
        mem_wd = rdata_r | found_onehot;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cur_r] <= mem_wd;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cur_r        <= '0;
      base_addr_r  <= ADDR_W'(32'h0010_0000);
      resv_end_r   <= ADDR_W'(32'h0010_0000);
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_BASE_ADDR) base_addr_r <= cfg_data;
        if (cfg_index == CFG_RESV_END)  resv_end_r  <= cfg_data;
      end

      if (resp_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          if (cur_r == SWEEP_LAST_IDX) begin
            state_r <= ST_IDLE;
          end else begin
            cur_r <= word_idx_t'(cur_r + 1'b1);
          end
        end

        ST_IDLE: begin
          if (in_tvalid) begin
            res_addr_r <= '0;
            unique case (opcode_t'(in_tuser))
              OP_INIT: begin
                res_status_r <= STATUS_OK;
                state_r      <= ST_CALC_CNT;
              end
              OP_MARK_USED, OP_MARK_FREE: begin
                mark_set_r <= (opcode_t'(in_tuser) == OP_MARK_USED);
                cur_r      <= in_page[BIT_IDX_W +: WORD_IDX_W];
                bit_r      <= in_page[BIT_IDX_W-1:0];
                if (in_beyond) begin
                  res_status_r <= STATUS_BEYOND;
                  state_r      <= ST_RESP;
                end else begin
                  res_status_r <= STATUS_OK;
                  state_r      <= ST_MARK_RD;
                end
              end
              OP_ALLOC: begin
                cur_r        <= start_page[BIT_IDX_W +: WORD_IDX_W];
                bit_r        <= start_page[BIT_IDX_W-1:0];
                first_word_r <= 1'b1;
                if (start_page >= SCAN_PAGES_R) begin
                  res_status_r <= STATUS_FULL;
                  state_r      <= ST_RESP;
                end else begin
                  res_status_r <= STATUS_OK;
                  state_r      <= ST_ALLOC_RD;
                end
              end
              default: begin
                res_status_r <= STATUS_OK;
                state_r      <= ST_RESP;
              end
            endcase
          end
        end

        ST_CALC_CNT: begin
          // last_r holds the page count of the reservation until the next step.
          first_r <= start_page;
          last_r  <= (resv_end_r > base_addr_r) ? span_pages : '0;
          state_r <= ST_CALC_LAST;
        end

        ST_CALC_LAST: begin
          if (range_end > TOTAL_PAGES_R) begin
            last_r <= TOTAL_PAGES_R;
            if (last_r != '0) res_status_r <= STATUS_BEYOND;
          end else begin
            last_r <= range_end;
          end
          cur_r   <= '0;
          state_r <= ST_SWEEP;
        end

        ST_SWEEP: begin
          if (cur_r == SWEEP_LAST_IDX) begin
            state_r <= ST_RESP;
          end else begin
            cur_r <= word_idx_t'(cur_r + 1'b1);
          end
        end

        ST_MARK_RD: begin
          state_r <= ST_MARK_WR;
        end

        ST_MARK_WR: begin
          state_r <= ST_RESP;
        end

        ST_ALLOC_RD: begin
          state_r <= ST_SCAN;
        end

        ST_SCAN: begin
          if (found) begin
            res_addr_r <= ADDR_W'({cur_r, found_bit}) << PAGE_SHIFT;
            state_r    <= ST_RESP;
          end else if (cur_r == SCAN_LAST_IDX) begin
            res_status_r <= STATUS_FULL;
            state_r      <= ST_RESP;
          end else begin
            cur_r        <= word_idx_t'(cur_r + 1'b1);
            first_word_r <= 1'b0;
          end
        end

        ST_RESP: begin
          if (resp_load) begin
            out_tdata_r <= res_addr_r;
            out_tuser_r <= res_status_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // Only a successful allocation carries a nonzero address.
  a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STATUS_OK |-> out_tdata == '0)
    else $error("failed or beyond result carries a nonzero address");

  // Returned addresses are always page aligned.
  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[PAGE_SHIFT-1:0] == '0)
    else $error("allocated address is not page aligned");

  // One transaction at a time: acceptance closes the input until the result is queued.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // The init sweep visits every word in order without skipping.
  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP && cur_r != SWEEP_LAST_IDX |=>
      state_r == ST_SWEEP && cur_r == word_idx_t'($past(cur_r) + 1'b1))
    else $error("init sweep left its word order");
`endif

endmodule

`default_nettype wire
